// ===== rtl/core/complex_sample_colormap_core_defines.svh =====
// assertion macros used by the checker file
`ifndef COMPLEX_SAMPLE_COLORMAP_CORE_DEFINES_SVH
`define COMPLEX_SAMPLE_COLORMAP_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define CSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define CSC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/csc_pkg.sv =====
package csc_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int ANGLE_STAGES_DEF = 16;
	localparam int CORDIC_SCALE     = 40;
	localparam int ANGLE_BITS       = 26;
	localparam int ATAN_BITS        = 22;

	typedef enum logic [1:0] {
		MODE_GRAY  = 2'd0,
		MODE_JET   = 2'd1,
		MODE_PHASE = 2'd2
	} map_mode_t;

	localparam logic [7:0] JET_BASE = 8'h7f;
	localparam logic [7:0] JET_FULL = 8'hff;
	localparam logic [7:0] JET_SEG1 = 8'd32;
	localparam logic [7:0] JET_SEG2 = 8'd96;
	localparam logic [7:0] JET_SEG3 = 8'd160;
	localparam logic [7:0] JET_SEG4 = 8'd224;
	localparam logic [7:0] JET_END3 = 8'd159;
	localparam logic [7:0] JET_END4 = 8'd223;
	localparam logic [7:0] JET_END5 = 8'd255;

	// atan(2^-i) in units of 2^-24 turn
	function automatic logic [ATAN_BITS-1:0] atan_entry(input logic [4:0] i);
		logic [ATAN_BITS-1:0] a;
		unique case (i)
			5'd0:  a = 22'd2097152;
			5'd1:  a = 22'd1238021;
			5'd2:  a = 22'd654136;
			5'd3:  a = 22'd332050;
			5'd4:  a = 22'd166669;
			5'd5:  a = 22'd83416;
			5'd6:  a = 22'd41718;
			5'd7:  a = 22'd20860;
			5'd8:  a = 22'd10430;
			5'd9:  a = 22'd5215;
			5'd10: a = 22'd2608;
			5'd11: a = 22'd1304;
			5'd12: a = 22'd652;
			5'd13: a = 22'd326;
			5'd14: a = 22'd163;
			5'd15: a = 22'd81;
			5'd16: a = 22'd41;
			5'd17: a = 22'd20;
			5'd18: a = 22'd10;
			5'd19: a = 22'd5;
			5'd20: a = 22'd3;
			5'd21: a = 22'd1;
			5'd22: a = 22'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/complex_sample_colormap_core.sv =====
// complex sample to rgb pixel mapper
//
// input: one word (real_part, imag_part) is taken at each clock edge where
// start is high and busy is low; busy stays low, so a word may enter on
// every cycle. output: red, green, blue carry one pixel for exactly one
// cycle while done is high; the receiver cannot stall the pipeline.
// config: cfg_we with cfg_wdata writes map_mode (gray, jet, phase); write
// it only while no word is in flight. mode 3 maps as gray.
// throughput: one word per cycle. the depth is set by the square root
// unit (one root bit per stage) running beside the cordic (one rotation
// per stage), whichever of the two has more stages.
// reset: clears all valid bits and sets map_mode to gray; words in
// flight are dropped.
module complex_sample_colormap_core
	import csc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [SAMPLE_WIDTH-1:0] real_part,
	input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_wdata,
	output logic                           done,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int FB    = SW - 2;
	localparam int XW    = CORDIC_SCALE + 2;
	localparam int SCL   = CORDIC_SCALE - SW;
	localparam int STEPS = (SW > ANGLE_STAGES) ? SW : ANGLE_STAGES;
	localparam int SQW   = 2 * SW;
	localparam int REMW  = SW + 2;
	localparam int MW    = SW - 1;
	localparam int M255W = MW + 8;
	localparam int PRODW = M255W + 17;
	localparam int SH    = FB + 16;
	localparam logic [SW-1:0] ONE = SW'(1) << FB;

	logic [1:0] map_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q <= MODE_GRAY;
		end else if (cfg_we) begin
			map_mode_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// stage 1: capture
	logic                 valid_s1;
	logic signed [SW-1:0] re_s1, im_s1;
	logic [1:0]           mode_s1;

	// stage 2: squares and cordic pre-rotation
	logic                 valid_s2;
	logic [SQW-1:0]       sqre_s2, sqim_s2;
	logic signed [XW-1:0] x_s2, y_s2;
	logic [ANGLE_BITS-1:0] ang_s2;
	logic [1:0]           mode_s2;

	// stage 3: radicand
	logic                 valid_s3;
	logic [SQW-1:0]       rad_s3;
	logic signed [XW-1:0] x_s3, y_s3;
	logic [ANGLE_BITS-1:0] ang_s3;
	logic [1:0]           mode_s3;

	// stage 4: shared iteration pipe, one root bit and one rotation per step; a unit with fewer steps holds its value
	logic                  valid_s4 [STEPS];
	logic [SQW-1:0]        rad_s4   [STEPS];
	logic [REMW-1:0]       rem_s4   [STEPS];
	logic [SW-1:0]         root_s4  [STEPS];
	logic signed [XW-1:0]  x_s4     [STEPS];
	logic signed [XW-1:0]  y_s4     [STEPS];
	logic [ANGLE_BITS-1:0] ang_s4   [STEPS];
	logic [1:0]            mode_s4  [STEPS];

	logic                  valid_s5, valid_s6, valid_s7;
	logic [MW-1:0]         m_s5;
	logic [15:0]           hue_s5;
	logic [1:0]            mode_s5, mode_s6, mode_s7;
	logic [M255W-1:0]      m255_s6;
	logic [2:0]            sector_s6, sector_s7;
	logic [15:0]           f_s6;
	logic [PRODW-1:0]      tp_s7, qp_s7;
	logic [7:0]            idx_s7, v_s7;

	logic signed [XW-1:0] re_ext, im_ext;
	assign re_ext = XW'(re_s1) <<< SCL;
	assign im_ext = XW'(im_s1) <<< SCL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s5 <= valid_s4[STEPS-1];
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			done     <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		re_s1   <= real_part;
		im_s1   <= imag_part;
		mode_s1 <= map_mode_q;

		sqre_s2 <= SQW'(re_s1) * SQW'(re_s1);
		sqim_s2 <= SQW'(im_s1) * SQW'(im_s1);
		mode_s2 <= mode_s1;
		if (re_s1[SW-1]) begin
			x_s2   <= -re_ext;
			y_s2   <= -im_ext;
			ang_s2 <= ANGLE_BITS'(1) << 23;
		end else begin
			x_s2   <= re_ext;
			y_s2   <= im_ext;
			ang_s2 <= '0;
		end

		rad_s3  <= sqre_s2 + sqim_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		ang_s3  <= ang_s2;
		mode_s3 <= mode_s2;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic                  v_in;
		logic [SQW-1:0]        rad_in;
		logic [REMW-1:0]       rem_in, rem_sh;
		logic [SW-1:0]         root_in;
		logic signed [XW-1:0]  x_in, y_in;
		logic [ANGLE_BITS-1:0] ang_in;
		logic [1:0]            mode_in;

		if (k == 0) begin : g_first
			assign v_in    = valid_s3;
			assign rad_in  = rad_s3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = x_s3;
			assign y_in    = y_s3;
			assign ang_in  = ang_s3;
			assign mode_in = mode_s3;
		end else begin : g_next
			assign v_in    = valid_s4[k-1];
			assign rad_in  = rad_s4[k-1];
			assign rem_in  = rem_s4[k-1];
			assign root_in = root_s4[k-1];
			assign x_in    = x_s4[k-1];
			assign y_in    = y_s4[k-1];
			assign ang_in  = ang_s4[k-1];
			assign mode_in = mode_s4[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s4[k] <= 1'b0;
			end else begin
				valid_s4[k] <= v_in;
			end
		end

		if (k < SW) begin : g_root
			logic [REMW-1:0] trial;
			assign rem_sh = {rem_in[REMW-3:0], rad_in[SQW-1-2*k -: 2]};
			assign trial  = {root_in, 2'b01};
			always_ff @(posedge clk) begin
				if (rem_sh >= trial) begin
					rem_s4[k]  <= rem_sh - trial;
					root_s4[k] <= {root_in[SW-2:0], 1'b1};
				end else begin
					rem_s4[k]  <= rem_sh;
					root_s4[k] <= {root_in[SW-2:0], 1'b0};
				end
			end
		end else begin : g_root_hold
			assign rem_sh = rem_in;
			always_ff @(posedge clk) begin
				rem_s4[k]  <= rem_sh;
				root_s4[k] <= root_in;
			end
		end

		if (k < ANGLE_STAGES) begin : g_rot
			logic signed [XW-1:0]  dx, dy;
			logic [ANGLE_BITS-1:0] da;
			assign dx = y_in >>> k;
			assign dy = x_in >>> k;
			assign da = ANGLE_BITS'(atan_entry(5'(k)));
			always_ff @(posedge clk) begin
				if (!y_in[XW-1]) begin
					x_s4[k]   <= x_in + dx;
					y_s4[k]   <= y_in - dy;
					ang_s4[k] <= ang_in + da;
				end else begin
					x_s4[k]   <= x_in - dx;
					y_s4[k]   <= y_in + dy;
					ang_s4[k] <= ang_in - da;
				end
			end
		end else begin : g_rot_hold
			always_ff @(posedge clk) begin
				x_s4[k]   <= x_in;
				y_s4[k]   <= y_in;
				ang_s4[k] <= ang_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_s4[k]  <= rad_in;
			mode_s4[k] <= mode_in;
		end
	end

	logic [24:0] hue_sum;
	logic [18:0] h6;
	logic [M255W:0] v_sum;
	logic [PRODW:0] t_sum, q_sum;
	assign hue_sum = {1'b0, ang_s4[STEPS-1][23:0]} + 25'd128;
	assign h6      = {3'b000, hue_s5} * 19'd6;
	assign v_sum   = {1'b0, m255_s6} + (M255W+1)'(ONE >> 1);

	always_ff @(posedge clk) begin
		m_s5    <= (root_s4[STEPS-1] > ONE) ? ONE[MW-1:0] : root_s4[STEPS-1][MW-1:0];
		hue_s5  <= hue_sum[23:8];
		mode_s5 <= mode_s4[STEPS-1];

		m255_s6   <= M255W'(m_s5) * M255W'(255);
		sector_s6 <= h6[18:16];
		f_s6      <= h6[15:0];
		mode_s6   <= mode_s5;

		tp_s7     <= PRODW'(m255_s6) * PRODW'(f_s6);
		qp_s7     <= PRODW'(m255_s6) * PRODW'(17'h10000 - {1'b0, f_s6});
		idx_s7    <= m255_s6[FB+7:FB];
		v_s7      <= v_sum[FB+7:FB];
		sector_s7 <= sector_s6;
		mode_s7   <= mode_s6;
	end

	logic [7:0] t_c, q_c, r_c, g_c, b_c;
	assign t_sum = {1'b0, tp_s7} + ((PRODW+1)'(1) << (SH-1));
	assign q_sum = {1'b0, qp_s7} + ((PRODW+1)'(1) << (SH-1));
	assign t_c   = t_sum[SH+7:SH];
	assign q_c   = q_sum[SH+7:SH];

	always_comb begin
		r_c = idx_s7;
		g_c = idx_s7;
		b_c = idx_s7;
		if (mode_s7 == MODE_PHASE) begin
			unique case (sector_s7)
				3'd0: begin r_c = v_s7; g_c = t_c;  b_c = '0;   end
				3'd1: begin r_c = q_c;  g_c = v_s7; b_c = '0;   end
				3'd2: begin r_c = '0;   g_c = v_s7; b_c = t_c;  end
				3'd3: begin r_c = '0;   g_c = q_c;  b_c = v_s7; end
				3'd4: begin r_c = t_c;  g_c = '0;   b_c = v_s7; end
				default: begin r_c = v_s7; g_c = '0; b_c = q_c; end
			endcase
		end else if (mode_s7 == MODE_JET) begin
			priority if (idx_s7 < JET_SEG1) begin
				r_c = '0;
				g_c = '0;
				b_c = JET_BASE + 8'(idx_s7 << 2);
			end else if (idx_s7 < JET_SEG2) begin
				r_c = '0;
				g_c = 8'((idx_s7 - JET_SEG1) << 2);
				b_c = JET_FULL;
			end else if (idx_s7 < JET_SEG3) begin
				r_c = 8'((idx_s7 - JET_SEG2) << 2);
				g_c = JET_FULL;
				b_c = 8'((JET_END3 - idx_s7) << 2);
			end else if (idx_s7 < JET_SEG4) begin
				r_c = JET_FULL;
				g_c = 8'((JET_END4 - idx_s7) << 2);
				b_c = '0;
			end else begin
				r_c = 8'((JET_END5 - idx_s7) << 2) + JET_BASE;
				g_c = '0;
				b_c = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		red   <= r_c;
		green <= g_c;
		blue  <= b_c;
	end

endmodule

// ===== rtl/core/csc_checker.sv =====
`include "complex_sample_colormap_core_defines.svh"

module csc_checker
	import csc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    cfg_we,
	input logic [1:0]              cfg_wdata,
	input logic                    done,
	input logic [7:0]              red,
	input logic [7:0]              green,
	input logic [7:0]              blue
);

	localparam int STEPS   = (SAMPLE_WIDTH > ANGLE_STAGES) ? SAMPLE_WIDTH : ANGLE_STAGES;
	localparam int LATENCY = STEPS + 7;
	localparam int CW      = $clog2(LATENCY + 1);

	logic [1:0]    mode_q;
	logic [CW-1:0] warm_q;
	logic          warm;
	logic          accept;

	assign accept = start && !busy;
	assign warm   = (warm_q == CW'(LATENCY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRAY;
			warm_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (!warm) begin
				warm_q <= warm_q + CW'(1);
			end
		end
	end

	// each accepted word gives exactly one pixel, and no pixel comes without one
	`CSC_ASSERT(a_latency, warm |-> (done == $past(accept, LATENCY)), "done out of step with start")

	`CSC_ASSERT_NEVER(a_gray, done && mode_q != MODE_JET && mode_q != MODE_PHASE &&
		(red != green || green != blue), "gray pixel not neutral")

	`CSC_ASSERT(a_jet, (done && mode_q == MODE_JET) |->
		(red == 8'd0 || blue == 8'd0 || green == 8'hff), "jet pixel off the ramp")

	`CSC_ASSERT(a_phase, (done && mode_q == MODE_PHASE) |->
		(red == 8'd0 || green == 8'd0 || blue == 8'd0), "hue pixel has no zero channel")

endmodule

bind complex_sample_colormap_core csc_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH),
	.ANGLE_STAGES(ANGLE_STAGES)
) u_csc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.cfg_we(cfg_we),
	.cfg_wdata(cfg_wdata),
	.done(done),
	.red(red),
	.green(green),
	.blue(blue)
);

// ===== tb/complex_sample_colormap_core_tb.sv =====
`timescale 1ns / 100ps

module complex_sample_colormap_core_tb;
	import csc_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int STAGES = ANGLE_STAGES_DEF;
	localparam longint UNITY = 64'd1 << (SW - 2);
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int LATENCY = ((SW > STAGES) ? SW : STAGES) + 7;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	class pixel_scoreboard;
		logic [1:0] mode;
		pixel_t     pending[$];
		int         errors;

		function new();
			mode = MODE_GRAY;
			errors = 0;
		endfunction

		function automatic longint unsigned root_floor(longint unsigned n);
			longint unsigned r, bitv;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= r + bitv) begin
					n = n - (r + bitv);
					r = (r >> 1) + bitv;
				end else begin
					r = r >> 1;
				end
				bitv = bitv >> 2;
			end
			return r;
		endfunction

		// angle in turns, 16-bit fraction, by vectoring rotations
		function automatic logic [15:0] phase_turns(longint re, longint im);
			longint x, y, ang, dx, dy;
			longint unsigned a24;
			logic [15:0] h;
			x = re * (64'sd1 <<< (40 - SW));
			y = im * (64'sd1 <<< (40 - SW));
			ang = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				ang = 64'sd1 <<< 23;
			end
			for (int i = 0; i < STAGES && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					ang = ang + longint'(atan_entry(5'(i)));
				end else begin
					x = x - dx;
					y = y + dy;
					ang = ang - longint'(atan_entry(5'(i)));
				end
			end
			a24 = longint'(ang) & 64'hFFFFFF;
			h = 16'((a24 + 128) >> 8);
			return h;
		endfunction

		function automatic pixel_t map_sample(logic signed [SW-1:0] re_w,
				logic signed [SW-1:0] im_w);
			longint re, im, idx;
			longint unsigned mag, f, v, t, q, h6, sect;
			pixel_t p;
			int sh;
			re = re_w;
			im = im_w;
			mag = root_floor(longint'(re * re + im * im));
			if (mag > UNITY) mag = UNITY;
			p.r = 0; p.g = 0; p.b = 0;
			if (mode == MODE_PHASE) begin
				h6 = longint'(phase_turns(re, im)) * 6;
				sect = h6 >> 16;
				f = h6 & 64'hFFFF;
				sh = SW - 2 + 16;
				v = (mag * 255 + (UNITY >> 1)) >> (SW - 2);
				t = (mag * 255 * f + (64'd1 << (sh - 1))) >> sh;
				q = (mag * 255 * (65536 - f) + (64'd1 << (sh - 1))) >> sh;
				case (sect)
					0: begin p.r = v; p.g = t; end
					1: begin p.r = q; p.g = v; end
					2: begin p.g = v; p.b = t; end
					3: begin p.g = q; p.b = v; end
					4: begin p.r = t; p.b = v; end
					default: begin p.r = v; p.b = q; end
				endcase
			end else begin
				idx = longint'((mag * 255) >> (SW - 2));
				if (idx > 255) idx = 255;
				if (mode == MODE_JET) begin
					if (idx < JET_SEG1) begin
						p.b = JET_BASE + idx * 4;
					end else if (idx < JET_SEG2) begin
						p.g = (idx - JET_SEG1) * 4; p.b = JET_FULL;
					end else if (idx < JET_SEG3) begin
						p.r = (idx - JET_SEG2) * 4; p.g = JET_FULL;
						p.b = (JET_END3 - idx) * 4;
					end else if (idx < JET_SEG4) begin
						p.r = JET_FULL; p.g = (JET_END4 - idx) * 4;
					end else begin
						p.r = (JET_END5 - idx) * 4 + JET_BASE;
					end
				end else begin
					p.r = idx; p.g = idx; p.b = idx;
				end
			end
			return p;
		endfunction

		function void note_sample(logic signed [SW-1:0] re_w, logic signed [SW-1:0] im_w);
			pending.push_back(map_sample(re_w, im_w));
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			pixel_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected pixel %0d %0d %0d", r, g, b));
			end else begin
				e = pending.pop_front();
				if (r !== e.r) report($sformatf("red %0d, wanted %0d", r, e.r));
				if (g !== e.g) report($sformatf("green %0d, wanted %0d", g, e.g));
				if (b !== e.b) report($sformatf("blue %0d, wanted %0d", b, e.b));
			end
		endtask
	endclass

	logic clk, arst_n, start, busy, cfg_we, done;
	logic signed [SW-1:0] real_part, imag_part;
	logic [1:0] cfg_wdata;
	logic [7:0] red, green, blue;
	int cycles;
	bit calm;
	pixel_scoreboard sb;

	complex_sample_colormap_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.real_part(real_part), .imag_part(imag_part),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .red(red), .green(green), .blue(blue)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// monitor: words in, pixels out, mode writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.mode = cfg_wdata;
			if (start && !busy) sb.note_sample(real_part, imag_part);
			if (done) sb.check_pixel(red, green, blue);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task send_word(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		real_part <= re;
		imag_part <= im;
		do @(posedge clk); while (busy);
	endtask

	task write_mode(logic [1:0] m);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] rand_field(bit under_one);
		if (under_one) return SW'($signed($urandom_range(0, 23168)) - 11584);
		return SW'($urandom_range(0, 65535));
	endfunction

	logic signed [SW-1:0] corner_re[16] = '{0, 16'sh7fff, -16'sh8000, 16'sh4000, 0,
		-16'sh4000, 0, -16'sh8000, 1, -1, 16'sh2d41, -16'sh2d41, 16'sh7fff, 100,
		-16'sh1000, 16'sh3000};
	logic signed [SW-1:0] corner_im[16] = '{0, 16'sh7fff, -16'sh8000, 0, 16'sh4000,
		0, -16'sh4000, 0, 0, 0, 16'sh2d41, 16'sh2d41, -16'sh8000, -1,
		-16'sh0800, 16'sh0100};

	initial begin
		sb = new();
		cycles = 0;
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_GRAY;
		real_part = '0;
		imag_part = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners in phase mode, then the first five in jet
		write_mode(MODE_PHASE);
		foreach (corner_re[i]) send_word(corner_re[i], corner_im[i]);
		write_mode(MODE_JET);
		for (int i = 0; i < 5; i++) send_word(corner_re[i], corner_im[i]);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: write_mode(MODE_GRAY);
				1: write_mode(MODE_JET);
				2: write_mode(MODE_PHASE);
				default: write_mode(MODE_SPARE);
			endcase
			if (ph == 7) calm = 1;
			for (int n = 0; n < 110; n++) begin
				bit lowmag;
				lowmag = $urandom_range(0, 1);
				send_word(rand_field(lowmag), rand_field(lowmag));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/csc_pkg.sv
rtl/core/complex_sample_colormap_core.sv
rtl/core/csc_checker.sv
tb/complex_sample_colormap_core_tb.sv
